[rtl/core/dlus_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dlus_pkg: shared types and constants for the dense LU solver
// Fixed-point limits, input mode codes, sequencer state and phase encodings.
// ----------------------------------------------------------------------------
package dlus_pkg;

  localparam int unsigned DataW = 32;
  localparam logic signed [DataW-1:0] QMax = 32'sh7FFF_FFFF;
  localparam logic signed [DataW-1:0] QMin = 32'sh8000_0000;

  localparam logic InModeMatrix = 1'b0;
  localparam logic InModeVector = 1'b1;

  // Sequencer states, one-hot.
  typedef enum logic [10:0] {
    ST_LOAD  = 11'b000_0000_0001,
    ST_RDA   = 11'b000_0000_0010,
    ST_RDB   = 11'b000_0000_0100,
    ST_CAP   = 11'b000_0000_1000,
    ST_MUL   = 11'b000_0001_0000,
    ST_DIV   = 11'b000_0010_0000,
    ST_WR    = 11'b000_0100_0000,
    ST_NEXT  = 11'b000_1000_0000,
    ST_ORD   = 11'b001_0000_0000,
    ST_OCAP  = 11'b010_0000_0000,
    ST_OUT   = 11'b100_0000_0000
  } seq_state_t;

  // Phase of the solve.
  typedef enum logic [2:0] {
    PH_DIV = 3'b001,
    PH_UPD = 3'b010,
    PH_SUB = 3'b100
  } phase_t;

  function automatic logic signed [DataW-1:0] sat_q(input logic signed [65:0] v,
                                                     output logic ovf);
    logic signed [DataW-1:0] r;
    begin
      ovf = 1'b0;
      r = v[DataW-1:0];
      if (v > 66'sd2147483647) begin
        r = QMax;
        ovf = 1'b1;
      end else if (v < -66'sd2147483648) begin
        r = QMin;
        ovf = 1'b1;
      end
      return r;
    end
  endfunction

endpackage : dlus_pkg
`default_nettype wire

[rtl/core/dlus_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dlus_ram: generic single-port-write, single-port-read RAM
// Write at one address, registered read at another.
// ----------------------------------------------------------------------------
module dlus_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule : dlus_ram
`default_nettype wire

[rtl/core/dlus_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dlus_div: iterative signed fixed-point divider
// Computes a * 2^FRAC_BITS / b truncated toward zero, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module dlus_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] num,
  input  wire logic [31:0] den,
  output logic             done,
  output logic [63:0]      quot
);
  localparam int unsigned QW = 32 + FRAC_BITS;
  localparam int unsigned CW = $clog2(QW + 1);

  logic [QW-1:0] dvd_r, dvd_nxt;
  logic [32:0]   rem_r, rem_nxt;
  logic [31:0]   dvs_r;
  logic          neg_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r;
  logic [33:0]   trial;
  logic [31:0]   anum, aden;

  assign anum = num[31] ? (~num + 32'd1) : num;
  assign aden = den[31] ? (~den + 32'd1) : den;
  assign trial = {rem_r, dvd_r[QW-1]} - {2'b00, dvs_r};

  always_comb begin
    rem_nxt = {rem_r[31:0], dvd_r[QW-1]};
    dvd_nxt = {dvd_r[QW-2:0], 1'b0};
    if (!trial[33]) begin
      rem_nxt = trial[32:0];
      dvd_nxt[0] = 1'b1;
    end
    cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(QW);
        dvd_r  <= {anum, {FRAC_BITS{1'b0}}};
        rem_r  <= '0;
        dvs_r  <= aden;
        neg_r  <= num[31] ^ den[31];
      end else if (busy_r) begin
        dvd_r <= dvd_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_nxt;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign quot = neg_r ? (64'd0 - 64'(dvd_r)) : 64'(dvd_r);
endmodule : dlus_div
`default_nettype wire

[rtl/core/dense_lu_linear_solver.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dense_lu_linear_solver: LU (Doolittle, no pivoting) solver in Q16.16
// Loads a matrix and right-hand side, factors, substitutes, streams x out.
// ----------------------------------------------------------------------------
// Usage: elements arrive on the in_ channel, one per beat, into a matrix RAM
// and a vector RAM; loading takes one beat per cycle. A beat with tlast set
// starts the solve: input is stalled while the sequencer reads, modifies and
// writes entries one at a time. Each product step reads three operands,
// multiplies, rounds and subtracts, then writes and advances. Each quotient
// runs through the bit-serial divider; a zero divisor skips the divider and
// saturates the result. The sequencer has a single shared multiplier and a
// single shared divider. The N results then leave on the out_ channel one at
// a time, the last carrying tlast; each result waits in the output register
// while the receiver holds tready low. The size register is written through
// cfg_; the user must write it only while idle, as the block itself does not
// enforce this. Reset returns to loading, clears the flags and sets the size
// register to 8; the RAM contents are undefined until written.
// ----------------------------------------------------------------------------
module dense_lu_linear_solver #(
  parameter int unsigned MAX_N     = 8,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_data,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // tdata, from bit 0: row[2:0], col[5:3], value[37:6], zero pad to 40 bits
  input  wire logic [39:0] in_tdata,
  // tuser: mode
  input  wire logic        in_tuser,
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // tdata, from bit 0: index[2:0], solution[34:3], zero pad to 40 bits
  output logic [39:0]      out_tdata,
  // tuser, from bit 0: singular, overflow
  output logic [1:0]       out_tuser,
  output logic             out_tlast
);
  import dlus_pkg::*;

  localparam int unsigned IW = $clog2(MAX_N);
  localparam int unsigned AW = 2 * IW;
  localparam int unsigned NW = IW + 1;

  seq_state_t st_r;
  phase_t     ph_r;
  logic [3:0]    size_r;
  logic [NW-1:0] n_r;
  logic [IW-1:0] k_r, i_r, j_r;
  logic [1:0]    flags_r;
  logic signed [31:0] a_r, b_r, c_r;
  logic signed [63:0] prod_r;
  logic [1:0]    mcnt_r;

  // RAM ports
  logic          m_we, v_we;
  logic [AW-1:0] m_wa, m_ra;
  logic [IW-1:0] v_wa, v_ra;
  logic [31:0]   m_wd, v_wd, m_rd, v_rd;

  dlus_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_mat (
    .clk, .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(m_ra), .rdata(m_rd));
  dlus_ram #(.WIDTH(32), .DEPTH(MAX_N)) u_vec (
    .clk, .we(v_we), .waddr(v_wa), .wdata(v_wd), .raddr(v_ra), .rdata(v_rd));

  logic        dv_start, dv_done;
  logic [63:0] dv_q;
  logic signed [31:0] dv_num, dv_den;
  dlus_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk, .rst_n, .start(dv_start), .num(dv_num), .den(dv_den),
    .done(dv_done), .quot(dv_q));

  // Input fields
  logic [2:0] in_row, in_col;
  logic [31:0] in_val;
  assign in_row = in_tdata[2:0];
  assign in_col = in_tdata[5:3];
  assign in_val = in_tdata[37:6];
  logic in_hs;
  assign in_tready = (st_r == ST_LOAD) && !out_tvalid;
  assign in_hs = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Back substitution runs i downwards; phase SUB is split by a bit.
  logic back_r;

  // Sizes
  logic [NW-1:0] n_eff;
  always_comb begin
    if (size_r == 4'd0) n_eff = NW'(1);
    else if (32'(size_r) > MAX_N) n_eff = NW'(MAX_N);
    else n_eff = NW'(size_r);
  end

  // Operand addresses by phase.
  // DIV: a = M(i,k), b = M(k,k) -> M(i,k) = a/b
  // UPD: a = M(i,j), b = M(i,k), c = M(k,j) -> M(i,j) = a - b*c
  // fwd: a = v[i], b = M(i,j), c = v[j] -> v[i] = a - b*c   (j < i)
  // back: same with j > i, then v[i] = a / M(i,i)
  logic [IW-1:0] last_i;
  assign last_i = IW'(n_r - NW'(1));

  // Rounding product and saturation.
  logic signed [65:0] prod_rnd, diff;
  logic signed [31:0] prod_sat, diff_sat, quo_sat;
  logic ovf_p, ovf_d, ovf_q;
  always_comb begin
    prod_rnd = (66'(prod_r) + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    prod_sat = sat_q(prod_rnd, ovf_p);
    diff = 66'(a_r) - 66'(prod_sat);
    diff_sat = sat_q(diff, ovf_d);
    quo_sat = sat_q(66'($signed(dv_q)), ovf_q);
  end

  logic div_zero;
  assign div_zero = (dv_den == 32'sd0);
  assign dv_num = a_r;
  assign dv_den = b_r;

  // Output register
  logic [IW-1:0] o_idx_r;

  always_comb begin
    m_we = 1'b0; m_wa = {IW'(in_row), IW'(in_col)}; m_wd = in_val;
    v_we = 1'b0; v_wa = IW'(in_row); v_wd = in_val;
    m_ra = '0; v_ra = '0;
    if (in_hs) begin
      m_we = (in_tuser == InModeMatrix) && (32'(in_row) < MAX_N) &&
             (32'(in_col) < MAX_N);
      v_we = (in_tuser == InModeVector) && (32'(in_row) < MAX_N);
    end
    unique case (ph_r)
      PH_DIV: begin
        m_ra = (st_r == ST_RDA) ? {i_r, k_r} : {k_r, k_r};
      end
      PH_UPD: begin
        m_ra = (st_r == ST_RDA) ? {i_r, j_r} : (st_r == ST_RDB) ? {i_r, k_r}
                                                                  : {k_r, j_r};
      end
      PH_SUB: begin
        m_ra = (st_r == ST_RDB && back_r && i_r == j_r) ? {i_r, i_r} : {i_r, j_r};
        v_ra = (st_r == ST_RDA) ? i_r : j_r;
      end
      default: ;
    endcase
    if (st_r == ST_ORD) v_ra = o_idx_r;
    if (st_r == ST_WR) begin
      unique case (ph_r)
        PH_DIV: begin m_we = 1'b1; m_wa = {i_r, k_r}; m_wd = c_r; end
        PH_UPD: begin m_we = 1'b1; m_wa = {i_r, j_r}; m_wd = c_r; end
        PH_SUB: begin v_we = 1'b1; v_wa = i_r; v_wd = c_r; end
        default: ;
      endcase
    end
  end

  // Sequencer. ST_RDA issues a read of the accumulator operand, ST_RDB the
  // first factor, ST_CAP the second; a/b/c then hold them.
  logic [1:0] rcnt_r;
  logic sub_div_r;   // back substitution final divide step
  assign dv_start = (st_r == ST_CAP) && (ph_r == PH_DIV || sub_div_r) && (rcnt_r == 2'd2)
                    && !div_zero;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_LOAD;
      ph_r <= PH_DIV;
      size_r <= 4'd8;
      flags_r <= 2'b00;
      out_tvalid <= 1'b0;
      back_r <= 1'b0;
      sub_div_r <= 1'b0;
      rcnt_r <= '0;
      mcnt_r <= '0;
    end else begin
      if (cfg_valid) size_r <= cfg_data;
      if (out_tvalid && out_tready) out_tvalid <= 1'b0;
      unique case (st_r)
        ST_LOAD: if (in_hs && in_tlast) begin
          n_r <= n_eff;
          flags_r <= 2'b00;
          k_r <= '0;
          if (n_eff == NW'(1)) begin
            ph_r <= PH_SUB; back_r <= 1'b1; i_r <= '0; j_r <= '0; sub_div_r <= 1'b1;
          end else begin
            ph_r <= PH_DIV; back_r <= 1'b0; i_r <= IW'(1); j_r <= IW'(1);
            sub_div_r <= 1'b0;
          end
          st_r <= ST_RDA;
        end
        ST_RDA: begin st_r <= ST_RDB; rcnt_r <= 2'd0; end
        ST_RDB: begin
          // data of the ST_RDA read arrives now
          if (ph_r == PH_SUB) a_r <= v_rd; else a_r <= m_rd;
          st_r <= ST_CAP; rcnt_r <= 2'd1;
        end
        ST_CAP: begin
          if (rcnt_r == 2'd1) begin
            b_r <= m_rd; rcnt_r <= 2'd2;
            if (ph_r == PH_SUB) c_r <= v_rd;
          end else begin
            if (ph_r == PH_UPD) c_r <= m_rd;
            if (ph_r == PH_DIV || sub_div_r) begin
              st_r <= ST_DIV;
              if (div_zero) flags_r[0] <= 1'b1;
            end else begin
              st_r <= ST_MUL; mcnt_r <= 2'd0;
            end
          end
        end
        ST_MUL: begin
          mcnt_r <= mcnt_r + 2'd1;
          if (mcnt_r == 2'd0) prod_r <= 64'(b_r) * 64'(c_r);
          else begin
            c_r <= diff_sat;
            if (ovf_p || ovf_d) flags_r[1] <= 1'b1;
            st_r <= ST_WR;
          end
        end
        ST_DIV: begin
          if (div_zero) begin
            c_r <= a_r[31] ? QMin : QMax; st_r <= ST_WR;
          end else if (dv_done) begin
            c_r <= quo_sat;
            if (ovf_q) flags_r[1] <= 1'b1;
            st_r <= ST_WR;
          end
        end
        ST_WR: st_r <= ST_NEXT;
        ST_NEXT: begin
          // The divide of row zero in back substitution ends the solve.
          if (ph_r == PH_SUB && back_r && sub_div_r && i_r == '0) st_r <= ST_ORD;
          else st_r <= ST_RDA;
          unique case (ph_r)
            PH_DIV: begin
              if (i_r == last_i) begin
                ph_r <= PH_UPD; i_r <= k_r + IW'(1); j_r <= k_r + IW'(1);
              end else i_r <= i_r + IW'(1);
            end
            PH_UPD: begin
              if (j_r != last_i) j_r <= j_r + IW'(1);
              else if (i_r != last_i) begin
                i_r <= i_r + IW'(1); j_r <= k_r + IW'(1);
              end else if (k_r + IW'(1) != last_i) begin
                k_r <= k_r + IW'(1); ph_r <= PH_DIV; i_r <= k_r + IW'(2);
              end else begin
                ph_r <= PH_SUB; back_r <= 1'b0; i_r <= IW'(1); j_r <= '0;
              end
            end
            PH_SUB: begin
              if (!back_r) begin
                if (j_r + IW'(1) != i_r) j_r <= j_r + IW'(1);
                else if (i_r != last_i) begin i_r <= i_r + IW'(1); j_r <= '0; end
                else begin
                  back_r <= 1'b1; i_r <= last_i; j_r <= last_i;
                  sub_div_r <= 1'b1;
                end
              end else if (!sub_div_r) begin
                if (j_r - IW'(1) != i_r) j_r <= j_r - IW'(1);
                else begin j_r <= i_r; sub_div_r <= 1'b1; end
              end else if (i_r != '0) begin
                i_r <= i_r - IW'(1); j_r <= last_i;
                sub_div_r <= (last_i == i_r - IW'(1));
              end else begin
                o_idx_r <= '0;
              end
            end
            default: ;
          endcase
        end
        ST_ORD: if (!out_tvalid || out_tready) st_r <= ST_OCAP;
        ST_OCAP: begin
          out_tvalid <= 1'b1;
          out_tdata <= {5'd0, v_rd, 3'(o_idx_r)};
          out_tuser <= flags_r;
          out_tlast <= (o_idx_r == last_i);
          st_r <= ST_OUT;
        end
        ST_OUT: if (out_tready) begin
          if (o_idx_r == last_i) st_r <= ST_LOAD;
          else begin o_idx_r <= o_idx_r + IW'(1); st_r <= ST_ORD; end
        end
        default: st_r <= ST_LOAD;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_LOAD) |-> !in_tready) else $error("input accepted during solve");
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result dropped under stall");
  a_div_only: assert property (@(posedge clk) disable iff (!rst_n)
    dv_done |-> (st_r == ST_DIV)) else $error("divider finished outside divide");
`endif
endmodule : dense_lu_linear_solver
`default_nettype wire

[bench/dense_lu_linear_solver_checker.sv]
// ----------------------------------------------------------------------------
// Solution checker for the dense LU solver
// Watches the configuration, element and solution channels, keeps its own
// copy of the matrix, vector and size, solves in fixed point on every beat
// with tlast, and compares each solution beat with the oldest prediction.
// ----------------------------------------------------------------------------
module dense_lu_linear_solver_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [3:0]  cfg_data,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [39:0] in_tdata,
  input  wire logic        in_tuser,
  input  wire logic        in_tlast,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [39:0] out_tdata,
  input  wire logic [1:0]  out_tuser,
  input  wire logic        out_tlast,
  output int               pending,
  output int               fail_count
);
  import dlus_pkg::*;

  typedef struct packed {
    logic [2:0]         index;
    logic signed [31:0] solution;
    logic               singular;
    logic               overflow;
    logic               final_res;
  } solution_t;

  logic signed [31:0] mat [8][8];
  logic signed [31:0] vec [8];
  logic [3:0]         size_reg;
  logic               sing_flag, ovf_flag;
  solution_t          solutions_due[$];

  function automatic logic signed [31:0] q_sat(longint v);
    if (v > longint'(QMax)) begin
      ovf_flag = 1'b1;
      return QMax;
    end
    if (v < longint'(QMin)) begin
      ovf_flag = 1'b1;
      return QMin;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] q_mul(logic signed [31:0] a, logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b) + (longint'(1) <<< 15);
    return q_sat(p >>> 16);
  endfunction

  function automatic logic signed [31:0] q_div(logic signed [31:0] a, logic signed [31:0] b);
    longint num;
    if (b == 0) begin
      sing_flag = 1'b1;
      return (a >= 0) ? QMax : QMin;
    end
    num = longint'(a) <<< 16;
    return q_sat(num / longint'(b));
  endfunction

  function automatic logic signed [31:0] q_sub(logic signed [31:0] a, logic signed [31:0] b);
    return q_sat(longint'(a) - longint'(b));
  endfunction

  function automatic void lu_solve();
    int n;
    logic signed [31:0] s;
    solution_t r;
    n = (size_reg == 0) ? 1 : (size_reg > 8) ? 8 : int'(size_reg);
    sing_flag = 1'b0;
    ovf_flag = 1'b0;
    for (int k = 0; k + 1 < n; k++) begin
      for (int i = k + 1; i < n; i++) mat[i][k] = q_div(mat[i][k], mat[k][k]);
      for (int i = k + 1; i < n; i++)
        for (int j = k + 1; j < n; j++)
          mat[i][j] = q_sub(mat[i][j], q_mul(mat[i][k], mat[k][j]));
    end
    for (int i = 1; i < n; i++) begin
      s = vec[i];
      for (int j = 0; j < i; j++) s = q_sub(s, q_mul(mat[i][j], vec[j]));
      vec[i] = s;
    end
    for (int i = n - 1; i >= 0; i--) begin
      s = vec[i];
      for (int j = n - 1; j > i; j--) s = q_sub(s, q_mul(mat[i][j], vec[j]));
      vec[i] = q_div(s, mat[i][i]);
    end
    for (int i = 0; i < n; i++) begin
      r.index = i[2:0];
      r.solution = vec[i];
      r.singular = sing_flag;
      r.overflow = ovf_flag;
      r.final_res = (i == n - 1);
      solutions_due.push_back(r);
    end
  endfunction

  initial begin
    pending = 0;
    fail_count = 0;
    size_reg = 4'd8;
  end

  always @(posedge clk) begin
    solution_t got, want;
    if (!rst_n) begin
      size_reg = 4'd8;
    end else begin
      if (cfg_valid && cfg_ready) size_reg = cfg_data;
      if (in_tvalid && in_tready) begin
        if (in_tuser == InModeVector) vec[in_tdata[2:0]] = in_tdata[37:6];
        else mat[in_tdata[2:0]][in_tdata[5:3]] = in_tdata[37:6];
        if (in_tlast) lu_solve();
      end
      if (out_tvalid && out_tready) begin
        got.index = out_tdata[2:0];
        got.solution = out_tdata[34:3];
        got.singular = out_tuser[0];
        got.overflow = out_tuser[1];
        got.final_res = out_tlast;
        if (solutions_due.size() == 0) begin
          $error("solution beat with nothing predicted: index %0d value %h",
                 got.index, got.solution);
          fail_count++;
        end else begin
          want = solutions_due.pop_front();
          if (got.index !== want.index) begin
            $error("index: expected %0d, got %0d", want.index, got.index);
            fail_count++;
          end
          if (got.solution !== want.solution) begin
            $error("solution: expected %h, got %h", want.solution, got.solution);
            fail_count++;
          end
          if (got.singular !== want.singular) begin
            $error("singular: expected %b, got %b", want.singular, got.singular);
            fail_count++;
          end
          if (got.overflow !== want.overflow) begin
            $error("overflow: expected %b, got %b", want.overflow, got.overflow);
            fail_count++;
          end
          if (got.final_res !== want.final_res) begin
            $error("final_res: expected %b, got %b", want.final_res, got.final_res);
            fail_count++;
          end
        end
      end
      pending = solutions_due.size();
    end
  end

endmodule

[bench/dense_lu_linear_solver_tb.sv]
// ----------------------------------------------------------------------------
// Testbench for the dense LU solver
// Loads directed and random systems of varying size, writes the size between
// solves, throttles both stream sides at random and reports the verdict.
// ----------------------------------------------------------------------------
module dense_lu_linear_solver_tb;
  import dlus_pkg::*;

  localparam int WatchdogLimit = 40000;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid, cfg_ready;
  logic [3:0]  cfg_data;
  logic        in_tvalid, in_tready, in_tuser, in_tlast;
  logic [39:0] in_tdata;
  logic        out_tvalid, out_tready, out_tlast;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;
  int          pending, fail_count;
  int          item_count;
  int          last_n;
  bit          hold_off_req;

  typedef struct {
    logic               mode;
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [31:0] value;
  } element_t;

  dense_lu_linear_solver uut (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_data,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast
  );

  dense_lu_linear_solver_checker checker_i (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_data,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .pending, .fail_count
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Cycles in which no beat moves on any channel end the run.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WatchdogLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Receiver: short random stalls, a few long ones, stretches of none, and
  // one long hold-off on request, long enough to outlast any solve.
  initial begin
    int len;
    out_tready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_tready <= 1'b0;
        repeat (5000) @(posedge clk);
      end else begin
        case ($urandom_range(0, 9))
          0: begin
            out_tready <= 1'b0;
            len = $urandom_range(20, 80);
          end
          1, 2: begin
            out_tready <= 1'b1;
            len = $urandom_range(50, 200);
          end
          default: begin
            out_tready <= 1'($urandom_range(0, 1));
            len = $urandom_range(1, 4);
          end
        endcase
        for (int c = 0; c < len && !hold_off_req; c++) @(posedge clk);
      end
    end
  end

  task automatic send_element(element_t e, logic last);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser <= e.mode;
    in_tdata <= {2'b00, e.value, e.col, e.row};
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    item_count++;
    gap = ($urandom_range(0, 2) == 0) ? 0 :
          ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait for every predicted solution and let the solver settle, then write the size.
  task automatic set_size(logic [3:0] size_val);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= size_val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_system(element_t elems[$]);
    for (int i = 0; i < elems.size(); i++) send_element(elems[i], i == elems.size() - 1);
  endtask

  function automatic element_t make_element(logic mode, int r, int c, logic signed [31:0] v);
    element_t e;
    e.mode = mode;
    e.row = r[2:0];
    e.col = c[2:0];
    e.value = v;
    return e;
  endfunction

  function automatic logic signed [31:0] pick_value(bit tame, bit diag);
    logic signed [31:0] v;
    if (!tame) return $urandom;
    if ($urandom_range(0, 15) == 0) return 32'sd0;
    if (diag) begin
      v = $urandom_range(2 << 16, 8 << 16);
      return $urandom_range(0, 1) ? -v : v;
    end
    return $signed($urandom_range(0, 4 << 16)) - (2 << 16);
  endfunction

  initial begin
    element_t sys[$];
    element_t t;
    int n, k;
    int set_count;
    bit tame;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = 4'd0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = InModeMatrix;
    in_tlast = 1'b0;
    item_count = 0;
    hold_off_req = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Size zero acts as one; a zero pivot saturates to the largest value.
    set_size(4'd0);
    sys = {make_element(InModeMatrix, 0, 0, 32'sd0), make_element(InModeVector, 0, 0, QMax)};
    send_system(sys);
    set_size(4'd1);
    sys = {make_element(InModeMatrix, 0, 0, QMin), make_element(InModeVector, 0, 0, QMin)};
    send_system(sys);
    // Reuse of the stored factor with a new right-hand side.
    sys = {make_element(InModeVector, 0, 0, -32'sd1)};
    send_system(sys);
    set_size(4'd2);
    sys = {make_element(InModeMatrix, 0, 0, 32'sh0001_0000),
           make_element(InModeMatrix, 0, 1, QMax),
           make_element(InModeMatrix, 1, 0, QMin),
           make_element(InModeMatrix, 1, 1, 32'sh0001_0000),
           make_element(InModeVector, 0, 0, QMin),
           make_element(InModeVector, 1, 0, QMax)};
    send_system(sys);
    // Zero U diagonal in the second row.
    sys = {make_element(InModeMatrix, 0, 0, 32'sh0001_0000),
           make_element(InModeMatrix, 0, 1, 32'sh0001_0000),
           make_element(InModeMatrix, 1, 0, 32'sh0001_0000),
           make_element(InModeMatrix, 1, 1, 32'sh0001_0000),
           make_element(InModeVector, 0, 0, 32'sh0001_0000),
           make_element(InModeVector, 1, 0, 32'sh0002_0000)};
    send_system(sys);
    last_n = 2;

    set_count = 0;
    while (item_count < 370) begin
      set_count++;
      if (set_count == 4) begin
        // The receiver holds off while the next beat waits at the stalled input.
        hold_off_req = 1'b1;
        sys = {make_element(InModeVector, 0, 0, pick_value(1'b1, 1'b0))};
        send_system(sys);
        continue;
      end
      if ($urandom_range(0, 9) == 0) begin
        // Solve again on the factors left in place.
        set_size(last_n[3:0]);
        sys = {make_element(InModeVector, $urandom_range(0, last_n - 1), $urandom_range(0, 7),
                            pick_value($urandom_range(0, 3) != 0, 1'b0))};
        send_system(sys);
        continue;
      end
      k = $urandom_range(0, 9);
      n = (k < 2) ? 1 : (k < 5) ? 2 : (k < 7) ? 3 : (k < 8) ? 4 : (k < 9) ? $urandom_range(5, 7) : 8;
      if (n == 1 && $urandom_range(0, 1)) set_size(4'd0);
      else if (n == 8 && $urandom_range(0, 1)) set_size(4'($urandom_range(9, 15)));
      else set_size(n[3:0]);
      tame = ($urandom_range(0, 3) != 0);
      sys = {};
      for (int r = 0; r < n; r++) begin
        for (int c = 0; c < n; c++)
          sys.push_back(make_element(InModeMatrix, r, c, pick_value(tame, r == c)));
        sys.push_back(make_element(InModeVector, r, $urandom_range(0, 7), pick_value(tame, 1'b0)));
      end
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 3))
          sys.push_back(make_element(1'($urandom_range(0, 1)), $urandom_range(0, 7),
                                     $urandom_range(0, 7), $urandom));
      for (int i = sys.size() - 1; i > 0; i--) begin
        k = $urandom_range(0, i);
        t = sys[i];
        sys[i] = sys[k];
        sys[k] = t;
      end
      send_system(sys);
      last_n = n;
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[files.f]
rtl/core/dlus_pkg.sv
rtl/core/dlus_ram.sv
rtl/core/dlus_div.sv
rtl/core/dense_lu_linear_solver.sv
bench/dense_lu_linear_solver_checker.sv
bench/dense_lu_linear_solver_tb.sv
